[sv/flps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_pkg
// shared constants, command codes and controller/datapath structs
// ----------------------------------------------------------------------------
package flps_pkg;
   localparam int TABLE_SLOTS_DEF = 64;
   localparam int KEY_BYTES_DEF   = 32;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   localparam logic [2:0] SIZE_LOG2_RESET = 3'd6;

   // commands from controller to datapath
   typedef struct packed {
      logic key_clear;    // reset hash, length, overflow
      logic probe_start;  // load slot pointer from hash, set probe count to one
      logic probe_step;   // advance slot pointer
      logic cmp_start;    // zero byte index
      logic cmp_step;     // advance byte index
      logic write_start;  // begin storing key in current slot
      logic write_step;   // store one byte
      logic write_done;   // set valid, bump count
      logic table_clear;  // drop all entries
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic key_empty;
      logic key_over;
      logic slot_free;     // current slot not valid
      logic len_match;     // valid and same length
      logic byte_match;    // stored byte equals key byte (registered read)
      logic cmp_last;      // byte index at last key byte
      logic probe_last;    // probe visited every active slot
      logic write_last;
   } sts_type;
endpackage

[sv/flps_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_stream_if
// valid/ready channel carrying a request or a response payload
// ----------------------------------------------------------------------------
interface flps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] key_byte;
   modport source (output valid, command, key_byte, input ready);
   modport sink   (input valid, command, key_byte, output ready);
endinterface

interface flps_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic       inserted;
   logic [1:0] status;
   logic [6:0] entry_count;
   modport source (output valid, found, inserted, status, entry_count, input ready);
   modport sink   (input valid, found, inserted, status, entry_count, output ready);
endinterface

[sv/flps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_datapath
// hash accumulator, key buffer, slot table and probe/compare pointers
// ----------------------------------------------------------------------------
module flps_datapath #(
   parameter int TABLE_SLOTS = flps_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BYTES   = flps_pkg::KEY_BYTES_DEF,
   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
   localparam int KW = $clog2(KEY_BYTES),
   localparam int LW = $clog2(KEY_BYTES + 1),
   localparam int CW = $clog2(TABLE_SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_take,
   input  logic [7:0]            key_byte,
   input  logic [2:0]            size_log2,
   input  flps_pkg::ctl_type     ctl,
   output flps_pkg::sts_type     sts,
   output logic [CW-1:0]         count
);
   localparam int MW = SW + KW;

   logic [31:0]   hash_ff, hash_in;
   logic [LW-1:0] len_ff;
   logic          over_ff;
   logic [7:0]    kbuf [KEY_BYTES];
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [LW-1:0] slen [TABLE_SLOTS];
   logic [LW-1:0] slen_rd_ff;
   logic [7:0]    sbytes [TABLE_SLOTS << KW];
   logic [CW-1:0] count_ff;
   logic [SW-1:0] slot_ff, slot_in, mask;
   logic [SW:0]   probe_ff;
   logic [KW-1:0] idx_ff;
   logic [7:0]    rd_ff;
   logic [7:0]    kb_ff;
   logic [SW:0]   nslots;

   // active slot count, halved down to the table size
   always_comb begin
      nslots = (SW+1)'(1);
      for (int i = 1; i <= 7; i++)
         if (i <= int'(size_log2) && (1 << i) <= TABLE_SLOTS) nslots = (SW+1)'(1) << i;
      mask = SW'(nslots - (SW+1)'(1));
   end

   assign hash_in = (hash_ff ^ {24'd0, key_byte}) * flps_pkg::FNV_PRIME;

   always_ff @(posedge clock) begin
      if (reset || ctl.key_clear) begin
         hash_ff <= flps_pkg::FNV_BASIS;
         len_ff  <= '0;
         over_ff <= 1'b0;
      end else if (byte_take) begin
         hash_ff <= hash_in;
         if (len_ff < LW'(KEY_BYTES)) len_ff <= len_ff + LW'(1);
         else over_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take && len_ff < LW'(KEY_BYTES)) kbuf[len_ff[KW-1:0]] <= key_byte;
   end

   always_comb begin
      slot_in = slot_ff;
      if (ctl.probe_start) slot_in = hash_ff[SW-1:0] & mask;
      else if (ctl.probe_step) slot_in = (slot_ff + SW'(1)) & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         probe_ff <= '0;
         idx_ff   <= '0;
      end else begin
         slot_ff <= slot_in;
         if (ctl.probe_start) probe_ff <= (SW+1)'(1);
         else if (ctl.probe_step) probe_ff <= probe_ff + (SW+1)'(1);
         if (ctl.cmp_start || ctl.write_start) idx_ff <= '0;
         else if (ctl.cmp_step || ctl.write_step) idx_ff <= idx_ff + KW'(1);
      end
   end

   // key byte memory: one address per cycle, read every cycle, written on write_step
   always_ff @(posedge clock) begin
      if (ctl.write_step) sbytes[MW'({slot_ff, idx_ff})] <= kbuf[idx_ff];
      rd_ff <= sbytes[MW'({slot_ff, idx_ff})];
      kb_ff <= kbuf[idx_ff];
   end

   // length read follows the slot pointer so it lines up with slot_ff
   always_ff @(posedge clock) begin
      if (ctl.write_start) slen[slot_ff] <= len_ff;
      slen_rd_ff <= slen[slot_in];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.table_clear) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (ctl.write_done) begin
         valid_ff[slot_ff] <= 1'b1;
         count_ff <= count_ff + CW'(1);
      end
   end

   assign sts.key_empty  = (len_ff == '0);
   assign sts.key_over   = over_ff;
   assign sts.slot_free  = !valid_ff[slot_ff];
   assign sts.len_match  = valid_ff[slot_ff] && (slen_rd_ff == len_ff);
   assign sts.byte_match = (rd_ff == kb_ff);
   assign sts.cmp_last   = (LW'(idx_ff) + LW'(1) == len_ff);
   assign sts.probe_last = (probe_ff == nslots);
   assign sts.write_last = (LW'(idx_ff) + LW'(1) == len_ff);
   assign count = count_ff;
endmodule

[sv/flps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_ctrl
// sequencer for key collection, probe walk, compare and store
// ----------------------------------------------------------------------------
module flps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_key_byte,
   output logic               req_ready,
   output logic               byte_take,
   output logic               rsp_load,
   output logic               rsp_found,
   output logic               rsp_inserted,
   output logic [1:0]         rsp_status,
   input  logic               rsp_free,
   input  flps_pkg::sts_type  sts,
   output flps_pkg::ctl_type  ctl
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PROBE = 3'd1;
   localparam logic [2:0] S_CRD   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       ins_ff, ins_in;
   logic       fnd_ff, fnd_in, add_ff, add_in;
   logic [1:0] st_ff, st_in;

   assign req_ready = (state_ff == S_IDLE);
   assign byte_take = req_valid && req_ready && (req_key_byte != 8'd0);
   assign rsp_found = fnd_ff;
   assign rsp_inserted = add_ff;
   assign rsp_status = st_ff;

   always_comb begin
      state_in = state_ff;
      ins_in = ins_ff; fnd_in = fnd_ff; add_in = add_ff; st_in = st_ff;
      ctl = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready && req_key_byte == 8'd0) begin
               fnd_in = 1'b0; add_in = 1'b0; st_in = flps_pkg::ST_OK;
               ins_in = (req_command == flps_pkg::CMD_INSERT);
               if (req_command == flps_pkg::CMD_CLEAR) begin
                  ctl.table_clear = 1'b1;
                  state_in = S_DONE;
               end else if (sts.key_over) begin
                  st_in = flps_pkg::ST_LONG;
                  state_in = S_DONE;
               end else if (sts.key_empty) begin
                  state_in = S_DONE;
               end else begin
                  ctl.probe_start = 1'b1;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (sts.slot_free) begin
               if (ins_ff) begin
                  ctl.write_start = 1'b1;
                  state_in = S_WRITE;
               end else state_in = S_DONE;
            end else if (sts.len_match) begin
               ctl.cmp_start = 1'b1;
               state_in = S_CRD;
            end else if (sts.probe_last) begin
               if (ins_ff) st_in = flps_pkg::ST_FULL;
               state_in = S_DONE;
            end else ctl.probe_step = 1'b1;
         end
         // wait for registered byte read
         S_CRD: state_in = S_CMP;
         S_CMP: begin
            if (!sts.byte_match || sts.cmp_last) begin
               if (sts.byte_match) begin
                  fnd_in = 1'b1;
                  state_in = S_DONE;
               end else if (sts.probe_last) begin
                  if (ins_ff) st_in = flps_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  ctl.probe_step = 1'b1;
                  state_in = S_PROBE;
               end
            end else begin
               ctl.cmp_step = 1'b1;
               state_in = S_CRD;
            end
         end
         S_WRITE: begin
            ctl.write_step = 1'b1;
            if (sts.write_last) begin
               ctl.write_done = 1'b1;
               add_in = 1'b1;
               state_in = S_DONE;
            end
         end
         // hold here while the response register is still occupied
         S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               ctl.key_clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      ins_ff <= ins_in; fnd_ff <= fnd_in; add_ff <= add_in; st_ff <= st_in;
   end
endmodule

[sv/fnv1a_linear_probe_key_set_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_key_set_unit
// set of byte-string keys in a linear-probed table hashed with fnv-1a
// ----------------------------------------------------------------------------
// key bytes: one per cycle while idle, no result
// terminator: probes slots, then compares key bytes (a registered read, then the compare),
//   and on insert stores the key bytes; all byte traffic uses the single key-byte memory port
// response register holds one result; key bytes keep flowing while it waits,
//   the next result stalls in the last state until the register is taken
// synchronous reset empties the table at once (valid bits), size log2 = 6
module fnv1a_linear_probe_key_set_unit #(
   parameter int TABLE_SLOTS = flps_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BYTES   = flps_pkg::KEY_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   flps_req_if.sink   req,
   flps_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);
   localparam int CW = $clog2(TABLE_SLOTS + 1);

   flps_pkg::ctl_type ctl;
   flps_pkg::sts_type sts;
   logic [2:0]    size_ff;
   logic          byte_take, rsp_load, f, a;
   logic [1:0]    s;
   logic [CW-1:0] count;
   logic          vld_ff;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= flps_pkg::SIZE_LOG2_RESET;
      else if (csr_we) size_ff <= csr_wdata;
   end

   flps_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_command(req.command), .req_key_byte(req.key_byte),
      .req_ready(req.ready), .byte_take, .rsp_load,
      .rsp_found(f), .rsp_inserted(a), .rsp_status(s),
      .rsp_free(!vld_ff || rsp.ready), .sts, .ctl
   );

   flps_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
      .clock, .reset, .byte_take, .key_byte(req.key_byte),
      .size_log2(size_ff), .ctl, .sts, .count
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (rsp_load) vld_ff <= 1'b1;
      else if (rsp.ready) vld_ff <= 1'b0;
      if (rsp_load) begin
         rsp.found <= f;
         rsp.inserted <= a;
         rsp.status <= s;
         rsp.entry_count <= 7'(count);
      end
   end
   assign rsp.valid = vld_ff;
endmodule

[sv/flps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flps_checker
// port-level checks on the key set unit
// ----------------------------------------------------------------------------
module flps_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found,
   input logic       rsp_inserted,
   input logic [1:0] rsp_status,
   input logic [6:0] rsp_entry_count
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("response dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_inserted))
      else $error("found and inserted together");
   a_ins_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> rsp_status == flps_pkg::ST_OK && rsp_entry_count != 7'd0)
      else $error("insert with bad status or count");
   a_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == flps_pkg::ST_LONG |-> !rsp_found && !rsp_inserted)
      else $error("long key reported a hit");
endmodule

bind fnv1a_linear_probe_key_set_unit flps_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_found(rsp.found), .rsp_inserted(rsp.inserted),
   .rsp_status(rsp.status), .rsp_entry_count(rsp.entry_count)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the fnv-1a key set: keys stream in byte by byte, each terminator
// gives one response that is compared with a behavioral table model
// ----------------------------------------------------------------------------
module tb_top;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic       found;
      logic       inserted;
      logic [1:0] status;
      logic [6:0] entry_count;
   } rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_wdata = '0;

   flps_req_if req ();
   flps_rsp_if rsp ();

   fnv1a_linear_probe_key_set_unit dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // table model
   logic [31:0] mdl_hash;
   logic [7:0]  mdl_key [flps_pkg::KEY_BYTES_DEF];
   int          mdl_len;
   logic        mdl_over;
   logic        mdl_valid [flps_pkg::TABLE_SLOTS_DEF];
   int          mdl_slen [flps_pkg::TABLE_SLOTS_DEF];
   logic [7:0]  mdl_sbytes [flps_pkg::TABLE_SLOTS_DEF][flps_pkg::KEY_BYTES_DEF];
   int          mdl_count;
   logic [2:0]  mdl_size_log2;

   rsp_type expected_rsp [$];
   int  fail_count = 0;
   bit  rx_hold = 1'b0;
   bit  tx_gaps = 1'b1;

   initial begin
      req.valid = 1'b0;
      req.command = flps_pkg::CMD_LOOKUP;
      req.key_byte = 8'd0;
      rsp.ready = 1'b0;
      mdl_hash = flps_pkg::FNV_BASIS;
      mdl_len = 0;
      mdl_over = 1'b0;
      mdl_count = 0;
      mdl_size_log2 = flps_pkg::SIZE_LOG2_RESET;
      foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bit key_matches(int s);
      if (!mdl_valid[s] || mdl_slen[s] != mdl_len) return 0;
      for (int i = 0; i < mdl_len; i++)
         if (mdl_sbytes[s][i] != mdl_key[i]) return 0;
      return 1;
   endfunction

   // fold one transfer into the model; queue a response on the terminator
   task automatic predict_set_op(logic [1:0] cmd, logic [7:0] b);
      rsp_type r;
      int n, s;
      bit have_free;
      r = '0;
      if (b != 8'd0) begin
         mdl_hash = (mdl_hash ^ {24'd0, b}) * flps_pkg::FNV_PRIME;
         if (mdl_len < flps_pkg::KEY_BYTES_DEF) begin
            mdl_key[mdl_len] = b;
            mdl_len++;
         end else mdl_over = 1'b1;
         return;
      end
      if (cmd == flps_pkg::CMD_CLEAR) begin
         foreach (mdl_valid[i]) mdl_valid[i] = 1'b0;
         mdl_count = 0;
      end else if (mdl_over) begin
         r.status = flps_pkg::ST_LONG;
      end else if (mdl_len > 0) begin
         n = 1 << mdl_size_log2;
         while (n > flps_pkg::TABLE_SLOTS_DEF) n = n >> 1;
         s = mdl_hash & (n - 1);
         have_free = 0;
         for (int i = 0; i < n; i++) begin
            if (!mdl_valid[s]) begin
               have_free = 1;
               break;
            end
            if (key_matches(s)) begin
               r.found = 1'b1;
               break;
            end
            s = (s + 1) & (n - 1);
         end
         if (!r.found && cmd == flps_pkg::CMD_INSERT) begin
            if (have_free) begin
               mdl_valid[s] = 1'b1;
               mdl_slen[s] = mdl_len;
               for (int i = 0; i < mdl_len; i++) mdl_sbytes[s][i] = mdl_key[i];
               mdl_count++;
               r.inserted = 1'b1;
            end else r.status = flps_pkg::ST_FULL;
         end
      end
      r.entry_count = mdl_count[6:0];
      expected_rsp.push_back(r);
      mdl_hash = flps_pkg::FNV_BASIS;
      mdl_len = 0;
      mdl_over = 1'b0;
   endtask

   // valid stays up after a transfer until the next byte or an idle phase
   task automatic send_byte(logic [1:0] cmd, logic [7:0] b);
      int g;
      g = tx_gaps ? gap_len() : 0;
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.key_byte <= b;
      do @(posedge clock); while (!req.ready);
      predict_set_op(cmd, b);
   endtask

   // key bytes carry random commands; the command only counts on the terminator
   task automatic send_key(logic [1:0] cmd, int len, int alpha);
      for (int i = 0; i < len; i++)
         send_byte(2'($urandom_range(0, 3)), alpha == 0 ? 8'($urandom_range(1, 255))
                   : 8'($urandom_range(1, alpha)));
      send_byte(cmd, 8'd0);
   endtask

   task automatic send_fixed_key(logic [1:0] cmd, logic [7:0] b, int len);
      for (int i = 0; i < len; i++) send_byte(cmd, b);
      send_byte(cmd, 8'd0);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_size(logic [2:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      mdl_size_log2 = v;
      csr_we <= 1'b0;
   endtask

   // response side with random stalls
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with nothing expected");
            fail_count++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp.found !== e.found) begin
               $error("found exp %0d act %0d", e.found, rsp.found); fail_count++;
            end
            if (rsp.inserted !== e.inserted) begin
               $error("inserted exp %0d act %0d", e.inserted, rsp.inserted);
               fail_count++;
            end
            if (rsp.status !== e.status) begin
               $error("status exp %0d act %0d", e.status, rsp.status); fail_count++;
            end
            if (rsp.entry_count !== e.entry_count) begin
               $error("entry_count exp %0d act %0d", e.entry_count, rsp.entry_count);
               fail_count++;
            end
         end
      end
   end

   initial begin : rx_proc
      int g;
      @(negedge reset);
      forever begin
         if (rx_hold) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            rx_hold = 1'b0;
         end
         g = gap_len();
         rsp.ready <= (g == 0);
         @(posedge clock);
         if (g > 0) begin
            repeat (g - 1) @(posedge clock);
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic test_directed();
      send_byte(flps_pkg::CMD_LOOKUP, 8'd0);          // empty lookup
      send_byte(flps_pkg::CMD_INSERT, 8'd0);          // empty insert
      send_fixed_key(flps_pkg::CMD_INSERT, 8'hFF, 1);
      send_fixed_key(flps_pkg::CMD_INSERT, 8'hFF, 1); // present
      send_fixed_key(flps_pkg::CMD_LOOKUP, 8'hFF, 1);
      send_fixed_key(CMD_SPARE, 8'hFF, 1);            // command three is a lookup
      send_fixed_key(flps_pkg::CMD_INSERT, 8'h01, 32);
      send_fixed_key(flps_pkg::CMD_LOOKUP, 8'h01, 32);
      send_fixed_key(flps_pkg::CMD_INSERT, 8'h80, 33); // too long
      send_fixed_key(flps_pkg::CMD_CLEAR, 8'h55, 33);
      send_fixed_key(flps_pkg::CMD_LOOKUP, 8'hFF, 1);
   endtask

   // tiny table: fill, overflow, then shrink with entries outside the range
   task automatic test_sizes();
      write_size(3'd0);
      send_key(flps_pkg::CMD_INSERT, 2, 0);
      send_key(flps_pkg::CMD_INSERT, 2, 0);
      send_key(flps_pkg::CMD_LOOKUP, 2, 0);
      write_size(3'd7);
      send_key(flps_pkg::CMD_CLEAR, 0, 0);
      for (int i = 0; i < 20; i++)
         send_key(flps_pkg::CMD_INSERT, $urandom_range(1, 3), 4);
      write_size(3'd2);
      for (int i = 0; i < 10; i++)
         send_key(2'($urandom_range(0, 1)), $urandom_range(1, 3), 4);
   endtask

   task automatic test_backpressure();
      wait_drained();
      rx_hold = 1'b1;
      tx_gaps = 1'b0;
      for (int i = 0; i < 12; i++) send_key(flps_pkg::CMD_INSERT, 1, 0);
      tx_gaps = 1'b1;
      wait_drained();
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 150) begin
         int r, len;
         logic [1:0] cmd;
         r = $urandom_range(0, 99);
         len = (r < 85) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 32)
               : $urandom_range(33, 36);
         cmd = ($urandom_range(0, 60) == 0) ? flps_pkg::CMD_CLEAR
               : 2'($urandom_range(0, 3));
         if (cmd == flps_pkg::CMD_CLEAR && $urandom_range(0, 1)) cmd = flps_pkg::CMD_INSERT;
         send_key(cmd, len, $urandom_range(0, 1) ? 3 : 0);
         sent += len + 1;
         if ($urandom_range(0, 80) == 0) write_size(3'($urandom_range(0, 7)));
      end
      // fill the whole table with distinct keys and run past full
      write_size(3'd6);
      send_key(flps_pkg::CMD_CLEAR, 0, 0);
      for (int i = 0; i < 66; i++) send_fixed_key(flps_pkg::CMD_INSERT, 8'(i + 1), 1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_sizes();
      test_backpressure();
      test_random();
      wait_drained();
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule

[sim.f]
sv/flps_pkg.sv
sv/flps_stream_if.sv
sv/flps_datapath.sv
sv/flps_ctrl.sv
sv/fnv1a_linear_probe_key_set_unit.sv
sv/flps_checker.sv
verif/tb_top.sv
